[rtl/mlps_pkg.sv]
package mlps_pkg;

    // Fixed field widths of the channels and the register
    localparam int VALUE_W  = 16;
    localparam int CAP_W    = 26;
    localparam int PARTS_W  = 11;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_ELEMENTS = 1024;
    localparam int DEF_VALUE_BITS   = 16;

    // Outcome of one greedy pass, probe unit to search control
    typedef struct packed {
        logic done;
        logic fits;
    } t_probe_res;

endpackage

[rtl/mlps_in_if.sv]
interface mlps_in_if;
    import mlps_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] element_value;
    logic               last_element;

    modport source (output valid, output element_value, output last_element, input ready);
    modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

[rtl/mlps_out_if.sv]
interface mlps_out_if;
    import mlps_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] min_capacity;
    logic             status;

    modport source (output valid, output min_capacity, output status, input ready);
    modport sink   (input valid, input min_capacity, input status, output ready);
endinterface

[rtl/mlps_ram.sv]
module mlps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/mlps_probe.sv]
module mlps_probe #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 16,
    parameter int CW    = $clog2(MAX_ELEMENTS + 1),
    parameter int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
    parameter int SUM_W = VALUE_BITS + $clog2(MAX_ELEMENTS)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [SUM_W-1:0]             i_cap,
    input  logic [CW-1:0]                i_len,
    input  logic [mlps_pkg::PARTS_W-1:0] i_k,
    output logic                         o_rd_en,
    output logic [AW-1:0]                o_rd_addr,
    input  logic [VALUE_BITS-1:0]        i_rd_data,
    output mlps_pkg::t_probe_res         o_res
);
    import mlps_pkg::*;

    logic            r_busy;
    logic [CW-1:0]   r_idx;
    logic            r_rd_vld;
    logic            r_rd_last;
    logic [SUM_W:0]  r_sum;
    logic [CW-1:0]   r_parts;
    logic            r_done;
    logic            r_fits;

    logic            issue;
    logic            issue_last;
    logic [SUM_W:0]  sum_try;
    logic [SUM_W:0]  n_sum;
    logic [CW-1:0]   n_parts;

    // Read the stored words in order, one per cycle
    assign issue      = r_busy && (r_idx < i_len);
    assign issue_last = (r_idx == i_len - CW'(1));
    assign o_rd_en    = issue;
    assign o_rd_addr  = r_idx[AW-1:0];

    // Greedy step on the word returned by the RAM
    always_comb begin
        sum_try = r_sum + (SUM_W + 1)'(i_rd_data);
        if (sum_try <= (SUM_W + 1)'(i_cap)) begin
            n_sum   = sum_try;
            n_parts = r_parts;
        end else begin
            n_sum   = (SUM_W + 1)'(i_rd_data);
            n_parts = r_parts + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
            r_fits    <= 1'b0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_parts   <= CW'(1);
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
            r_idx     <= '0;
            r_sum     <= '0;
            r_parts   <= CW'(1);
        end else begin
            r_rd_vld  <= issue;
            r_rd_last <= issue && issue_last;
            r_done    <= 1'b0;
            if (issue) begin
                r_idx <= r_idx + CW'(1);
                if (issue_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_rd_vld) begin
                r_sum   <= n_sum;
                r_parts <= n_parts;
                if (r_rd_last) begin
                    r_done <= 1'b1;
                    r_fits <= (32'(n_parts) <= 32'(i_k));
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.fits = r_fits;
endmodule

[rtl/min_largest_partition_sum.sv]
// Channel   Dir  Word                              Handshake
// i_in      in   element_value, last_element       valid/ready
// o_out     out  min_capacity, status              valid/ready
// i_cfg     in   num_parts (i_cfg_wdata)           i_cfg_we, no wait
//
// While loading, the RAM write port stores each word that fits in the store.
// After the last word the search runs at most SUM_W + 1 probes; each probe is a
// greedy pass over the N stored words, and the RAM read port sets the pass length.
// Reset is synchronous, active low; the element RAM is not cleared, only
// entries of the current array are read.
// A result waiting on o_out does not stop loading of the next array; a
// second result holds the block in S_EMIT until the output register is free.
module min_largest_partition_sum #(
    parameter int MAX_ELEMENTS = mlps_pkg::DEF_MAX_ELEMENTS,
    parameter int VALUE_BITS   = mlps_pkg::DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mlps_pkg::PARTS_W-1:0] i_cfg_wdata,
    mlps_in_if.sink                      i_in,
    mlps_out_if.source                   o_out
);
    import mlps_pkg::*;

    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int SUM_W = VALUE_BITS + $clog2(MAX_ELEMENTS);

    typedef enum logic [1:0] {S_LOAD, S_MID, S_PROBE, S_EMIT} t_state;

    t_state                r_state, n_state;
    logic [PARTS_W-1:0]    r_parts_cfg;
    logic [CW-1:0]         r_count, n_count;
    logic [VALUE_BITS-1:0] r_largest, n_largest;
    logic [SUM_W-1:0]      r_total, n_total;
    logic [CW-1:0]         r_len, n_len;
    logic [PARTS_W-1:0]    r_k, n_k;
    logic [SUM_W:0]        r_low, n_low;
    logic [SUM_W:0]        r_high, n_high;
    logic [SUM_W-1:0]      r_best, n_best;
    logic                  r_err, n_err;
    logic [SUM_W-1:0]      r_mid, n_mid;
    logic                  r_start, n_start;
    logic                  r_out_vld, n_out_vld;
    logic [CAP_W-1:0]      r_out_cap, n_out_cap;
    logic                  r_out_status, n_out_status;

    logic                  in_acc;
    logic                  room;
    logic [VALUE_BITS-1:0] word;
    logic [CW-1:0]         acc_count;
    logic [VALUE_BITS-1:0] acc_largest;
    logic [SUM_W-1:0]      acc_total;
    logic [PARTS_W-1:0]    k_eff;
    logic [SUM_W+1:0]      mid_sum;

    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;
    t_probe_res            probe_res;

    assign i_in.ready = (r_state == S_LOAD);
    assign in_acc     = i_in.valid && i_in.ready;
    assign word       = VALUE_BITS'(i_in.element_value);
    assign room       = (32'(r_count) < MAX_ELEMENTS);
    assign k_eff      = (r_parts_cfg == '0) ? PARTS_W'(1) : r_parts_cfg;
    assign mid_sum    = (SUM_W + 2)'(r_low) + (SUM_W + 2)'(r_high);

    // Running count, largest word and total with the incoming word
    always_comb begin
        acc_count   = r_count;
        acc_largest = r_largest;
        acc_total   = r_total;
        if (room) begin
            acc_count = r_count + CW'(1);
            if (word > r_largest) begin
                acc_largest = word;
            end
            acc_total = r_total + SUM_W'(word);
        end
    end

    // Load, bound search and result hand-off
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_largest    = r_largest;
        n_total      = r_total;
        n_len        = r_len;
        n_k          = r_k;
        n_low        = r_low;
        n_high       = r_high;
        n_best       = r_best;
        n_err        = r_err;
        n_mid        = r_mid;
        n_start      = 1'b0;
        n_out_vld    = r_out_vld && !o_out.ready;
        n_out_cap    = r_out_cap;
        n_out_status = r_out_status;

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_count   = acc_count;
                    n_largest = acc_largest;
                    n_total   = acc_total;
                    if (i_in.last_element) begin
                        n_count   = '0;
                        n_largest = '0;
                        n_total   = '0;
                        n_len     = acc_count;
                        n_k       = k_eff;
                        if (32'(acc_count) < 32'(k_eff)) begin
                            n_best  = '0;
                            n_err   = 1'b1;
                            n_state = S_EMIT;
                        end else begin
                            n_low   = (SUM_W + 1)'(acc_largest);
                            n_high  = (SUM_W + 1)'(acc_total);
                            n_best  = acc_total;
                            n_err   = 1'b0;
                            n_state = S_MID;
                        end
                    end
                end
            end
            S_MID: begin
                if (r_low <= r_high) begin
                    n_mid   = SUM_W'(mid_sum >> 1);
                    n_start = 1'b1;
                    n_state = S_PROBE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_PROBE: begin
                if (probe_res.done) begin
                    if (probe_res.fits) begin
                        n_best = r_mid;
                        if (r_mid == '0) begin
                            n_state = S_EMIT;
                        end else begin
                            n_high  = (SUM_W + 1)'(r_mid) - (SUM_W + 1)'(1);
                            n_state = S_MID;
                        end
                    end else begin
                        n_low   = (SUM_W + 1)'(r_mid) + (SUM_W + 1)'(1);
                        n_state = S_MID;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_cap    = CAP_W'(r_best);
                    n_out_status = r_err;
                    n_state      = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_LOAD;
            r_parts_cfg  <= PARTS_W'(1);
            r_count      <= '0;
            r_largest    <= '0;
            r_total      <= '0;
            r_start      <= 1'b0;
            r_out_vld    <= 1'b0;
            r_len        <= '0;
            r_k          <= PARTS_W'(1);
            r_low        <= '0;
            r_high       <= '0;
            r_best       <= '0;
            r_err        <= 1'b0;
            r_mid        <= '0;
            r_out_cap    <= '0;
            r_out_status <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_parts_cfg <= i_cfg_wdata;
            end
            r_count      <= n_count;
            r_largest    <= n_largest;
            r_total      <= n_total;
            r_start      <= n_start;
            r_out_vld    <= n_out_vld;
            r_len        <= n_len;
            r_k          <= n_k;
            r_low        <= n_low;
            r_high       <= n_high;
            r_best       <= n_best;
            r_err        <= n_err;
            r_mid        <= n_mid;
            r_out_cap    <= n_out_cap;
            r_out_status <= n_out_status;
        end
    end

    // Element store
    mlps_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_ELEMENTS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (word),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Greedy pass over the stored array
    mlps_probe #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS),
        .CW           (CW),
        .AW           (AW),
        .SUM_W        (SUM_W)
    ) u_probe (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_cap     (r_mid),
        .i_len     (r_len),
        .i_k       (r_k),
        .o_rd_en   (ram_re),
        .o_rd_addr (ram_raddr),
        .i_rd_data (ram_rdata),
        .o_res     (probe_res)
    );

    assign o_out.valid        = r_out_vld;
    assign o_out.min_capacity = r_out_cap;
    assign o_out.status       = r_out_status;

    // Checks
    a_done_in_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        probe_res.done |-> (r_state == S_PROBE))
        else $error("probe finished outside a search step");

    a_err_zero_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_status) |-> (r_out_cap == '0))
        else $error("error result carries a capacity");

    a_bounds_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MID) |-> ((SUM_W + 2)'(r_low) <= (SUM_W + 2)'(r_high) + (SUM_W + 2)'(1)))
        else $error("search bounds crossed by more than one");

    a_no_read_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> !ram_re)
        else $error("store read while loading");
endmodule
